>>> sv/boxavg_pkg.sv
// ----------------------------------------------------------------------------
// Boxcar average package
// Shared widths, register indexes and types for the three-axis boxcar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package boxavg_pkg;

	localparam int WINDOW_DEF = 100;
	localparam int FIFO_DEPTH = 8;

	localparam int IN_W   = 96;
	localparam int OUT_W  = 104;
	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_BIAS_EN = 2'd0;
	localparam logic [1:0] REG_BIAS_X  = 2'd1;
	localparam logic [1:0] REG_BIAS_Y  = 2'd2;
	localparam logic [1:0] REG_BIAS_Z  = 2'd3;

	typedef logic signed [15:0] s16_t;
	typedef logic signed [16:0] s17_t;

	typedef struct packed {
		logic        bias_enable;
		s16_t [2:0]  bias;
	} cfg_t;

	// Exact running-sum width for a window of w signed 16-bit samples.
	function automatic int sum_width(input int w);
		return 16 + $clog2(w);
	endfunction

endpackage

`default_nettype wire

>>> sv/three_axis_boxcar_average_unit.sv
// ----------------------------------------------------------------------------
// Three-axis boxcar average unit
// Input items carry three accelerometer and three gyro samples. Each item
// replaces the oldest ring slot, updates the per-axis running sums and
// produces one result: the window average per accelerometer axis (divided
// by WINDOW, truncated toward zero) and the gyro rates, bias-corrected at
// 17 bits when bias_enable is set.
// Channels: s_axis in, m_axis out, APB port for the four registers.
// Registers from acceptance to m_axis_tvalid: stage 1, sum, divider, FIFO.
// Throughput: one item per cycle while s_axis_tready is high, set by the ring
// RAM's read and write per cycle on separate ports, forwarding on a shared slot.
// An 8-entry result FIFO holds finished items; s_axis_tready drops once
// 8 items are accepted and not yet taken, so a stalled receiver loses
// nothing and the pipeline keeps running until the FIFO is spoken for.
// Reset: ring slots read as zero until the ring position first wraps, sums
// and ring position cleared, bias_enable=1, biases zero; items accepted at once.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_boxcar_average_unit import boxavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// avg_x, avg_y, avg_z (16 each), rate_x, rate_y, rate_z (17 each), pad
	output logic      [OUT_W-1:0]  m_axis_tdata,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int SUM_W  = sum_width(WINDOW);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);

	cfg_t cfg;

	boxavg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic              accept, pop;
	logic [SLOT_W-1:0] ptr_q;
	logic              wrap_q;
	logic [OCC_W-1:0]  occ_q;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [SLOT_W-1:0] slot_s1;
	s16_t              acc_s1  [3];
	s16_t              gyro_s1 [3];
	logic              fwd_s1, rvld_s1;
	logic [47:0]       fwd_data_s1;
	logic [47:0]       wdata, rdata, old;

	logic signed [SUM_W-1:0] sum_q   [3];
	logic signed [SUM_W-1:0] sum_nxt [3];
	s17_t rate_nxt [3];
	s17_t rate_s2 [3], rate_s3 [3], rate_s4 [3], rate_s5 [3];
	s16_t avg [3];

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (occ_q < OCC_W'(FIFO_DEPTH));
	assign wdata         = {acc_s1[2], acc_s1[1], acc_s1[0]};

	boxavg_ram #(
		.WIDTH (48),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (slot_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// Ring slot and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			occ_q  <= '0;
			wrap_q <= 1'b0;
		end else begin
			if (accept) begin
				ptr_q <= (ptr_q == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(ptr_q + 1'b1);
				// every slot has been written once the position wraps
				if (ptr_q == SLOT_W'(WINDOW - 1)) begin
					wrap_q <= 1'b1;
				end
			end
			if (accept && !pop) begin
				occ_q <= OCC_W'(occ_q + 1'b1);
			end else if (!accept && pop) begin
				occ_q <= OCC_W'(occ_q - 1'b1);
			end
		end
	end

	// Stage 1: capture the item and the read-slot status
	always_ff @(posedge clk) begin
		slot_s1     <= ptr_q;
		fwd_s1      <= vld_s1 && (slot_s1 == ptr_q);
		fwd_data_s1 <= wdata;
		rvld_s1     <= wrap_q;
		for (int a = 0; a < 3; a++) begin
			acc_s1[a]  <= s_axis_tdata[16*a +: 16];
			gyro_s1[a] <= s_axis_tdata[48 + 16*a +: 16];
		end
	end

	// Take the word written in the same cycle as its read over the stale RAM word
	assign old = fwd_s1 ? fwd_data_s1 : (rvld_s1 ? rdata : '0);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_nxt[a] = sum_q[a]
				- SUM_W'(signed'(old[16*a +: 16]))
				+ SUM_W'(acc_s1[a]);
			rate_nxt[a] = cfg.bias_enable
				? s17_t'(17'(gyro_s1[a]) - 17'(signed'(cfg.bias[a])))
				: s17_t'(17'(gyro_s1[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
			end
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (vld_s1) begin
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= sum_nxt[a];
				end
			end
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Delay the rates to line up with the divider output
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			rate_s2[a] <= rate_nxt[a];
			rate_s3[a] <= rate_s2[a];
			rate_s4[a] <= rate_s3[a];
			rate_s5[a] <= rate_s4[a];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		boxavg_div #(
			.WINDOW (WINDOW)
		) u_div (
			.clk (clk),
			.sum (sum_q[g]),
			.avg (avg[g])
		);
	end

	boxavg_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s5),
		.push_data ({5'd0, rate_s5[2], rate_s5[1], rate_s5[0], avg[2], avg[1], avg[0]}),
		.pop       (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

>>> sv/boxavg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read with enable.
// ----------------------------------------------------------------------------
`default_nettype none

module boxavg_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 100
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/boxavg_div.sv
// ----------------------------------------------------------------------------
// Window divider
// Three-stage signed divide by the window length, truncated toward zero,
// by reciprocal multiply with one remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module boxavg_div import boxavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                                 clk,
	input  wire logic signed [sum_width(WINDOW)-1:0]  sum,
	output s16_t                                      avg
);

	localparam int SUM_W = sum_width(WINDOW);
	localparam int MAG_W = SUM_W;
	localparam int K     = SUM_W;
	localparam int M_W   = SUM_W + 1;
	localparam int P_W   = MAG_W + M_W;
	localparam logic [M_W-1:0]   RECIP = M_W'((64'd1 << K) / WINDOW);
	localparam logic [MAG_W-1:0] WIN_C = MAG_W'(WINDOW);

	logic             neg_s1, neg_s2;
	logic [MAG_W-1:0] mag_s1, mag_s2;
	logic [P_W-1:0]   prod_s2;
	logic [MAG_W-1:0] q0, qw, rem, q;
	logic [15:0]      q16;

	always_ff @(posedge clk) begin
		neg_s1  <= sum[SUM_W-1];
		mag_s1  <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
		neg_s2  <= neg_s1;
		mag_s2  <= mag_s1;
		prod_s2 <= P_W'(mag_s1) * P_W'(RECIP);
	end

	// Estimate is low by at most one; fix it from the remainder.
	always_comb begin
		q0  = prod_s2[K +: MAG_W];
		qw  = q0 * WIN_C;
		rem = mag_s2 - qw;
		q   = (rem >= WIN_C) ? MAG_W'(q0 + 1'b1) : q0;
		q16 = q[15:0];
	end

	always_ff @(posedge clk) begin
		avg <= neg_s2 ? s16_t'(-q16) : s16_t'(q16);
	end

endmodule

`default_nettype wire

>>> sv/boxavg_fifo.sv
// ----------------------------------------------------------------------------
// Result FIFO
// Small register FIFO that holds finished items while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module boxavg_fifo #(
	parameter int WIDTH = 104,
	parameter int DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  out_valid,
	output logic      [WIDTH-1:0] out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[rd_q];
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (push && !do_pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (!push && do_pop) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/boxavg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file: bias enable and three gyro bias offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module boxavg_regs import boxavg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.bias_enable <= 1'b1;
			cfg.bias        <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BIAS_EN: cfg.bias_enable <= pwdata[0];
				REG_BIAS_X:  cfg.bias[0]     <= pwdata[15:0];
				REG_BIAS_Y:  cfg.bias[1]     <= pwdata[15:0];
				REG_BIAS_Z:  cfg.bias[2]     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BIAS_EN: prdata = {31'd0, cfg.bias_enable};
			REG_BIAS_X:  prdata = 32'(signed'(cfg.bias[0]));
			REG_BIAS_Y:  prdata = 32'(signed'(cfg.bias[1]));
			REG_BIAS_Z:  prdata = 32'(signed'(cfg.bias[2]));
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> tb/sv/three_axis_boxcar_average_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-axis boxcar average unit testbench
// Streams IMU sample sets through the unit and runs a local model of the
// accelerometer ring, the running sums and the gyro bias removal beside it.
// Each result is checked field by field. Register settings change only
// while the unit is idle. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module three_axis_boxcar_average_unit_tb;
	import boxavg_pkg::*;

	localparam int WIN = WINDOW_DEF;

	typedef struct packed {
		s16_t [2:0] accel;
		s16_t [2:0] gyro;
	} imu_t;

	typedef struct packed {
		s16_t [2:0] avg;
		s17_t [2:0] rate;
	} motion_t;

	typedef enum int {FILL_HIGH, FILL_LOW, FILL_CORNER, FILL_ANY} fill_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// avg_x, avg_y, avg_z (16 each), rate_x, rate_y, rate_z (17 each), pad
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Local copy of the unit's state and registers
	s16_t    ring_model [WIN][3];
	int      sum_model [3];
	int      slot_model;
	logic    bias_on_model;
	s16_t    bias_model [3];
	motion_t pending_results [$];
	int      error_count;
	bit      send_burst;
	bit      recv_burst;
	string   axis_tag [3] = '{"x", "y", "z"};

	three_axis_boxcar_average_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic motion_t predict_boxcar(input imu_t imu);
		motion_t res;
		int      q;
		int      g;
		for (int a = 0; a < 3; a++) begin
			// drop the oldest sample from the sum, add the new one
			sum_model[a] = sum_model[a] - ring_model[slot_model][a] + $signed(imu.accel[a]);
			ring_model[slot_model][a] = $signed(imu.accel[a]);
			q = sum_model[a] / WIN;
			res.avg[a] = q[15:0];
			g = $signed(imu.gyro[a]);
			if (bias_on_model)
				g = g - bias_model[a];
			res.rate[a] = g[16:0];
		end
		slot_model = (slot_model + 1) % WIN;
		return res;
	endfunction

	function automatic int draw_gap(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : int'($urandom_range(0, 13));
	endfunction

	function automatic logic [15:0] pick_value(input fill_t fill);
		case (fill)
			FILL_HIGH: return 16'h7FFF - 16'($urandom_range(0, 3));
			FILL_LOW:  return 16'h8000 + 16'($urandom_range(0, 3));
			FILL_CORNER: begin
				case ($urandom_range(0, 5))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'hFFFF;
					4: return 16'h0001;
					default: return 16'($urandom);
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic imu_t make_imu(input fill_t fill);
		imu_t imu;
		for (int a = 0; a < 3; a++) begin
			imu.accel[a] = pick_value(fill);
			imu.gyro[a]  = pick_value($urandom_range(0, 1) ? FILL_CORNER : FILL_ANY);
		end
		return imu;
	endfunction

	function automatic imu_t imu_of(input logic [15:0] ax, ay, az, gx, gy, gz);
		imu_t imu;
		imu.accel[0] = ax;
		imu.accel[1] = ay;
		imu.accel[2] = az;
		imu.gyro[0]  = gx;
		imu.gyro[1]  = gy;
		imu.gyro[2]  = gz;
		return imu;
	endfunction

	task automatic send_imu(input imu_t imu);
		int gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {imu.gyro[2], imu.gyro[1], imu.gyro[0],
		                  imu.accel[2], imu.accel[1], imu.accel[0]};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_boxcar(imu));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_BIAS_EN: bias_on_model = value[0];
			REG_BIAS_X:  bias_model[0] = value[15:0];
			REG_BIAS_Y:  bias_model[1] = value[15:0];
			REG_BIAS_Z:  bias_model[2] = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Reset defaults; the ring is still mostly empty slots counted as zero
	task automatic test_window_fill();
		send_imu(imu_of(16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h8000, 16'h0000));
		send_imu(imu_of(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000));
		send_imu(imu_of(16'hFFFF, 16'h0063, 16'hFF9D, 16'h0000, 16'h7FFF, 16'h7FFF));
		send_imu(imu_of(16'h8000, 16'h7FFF, 16'h0064, 16'h1234, 16'hEDCC, 16'h0001));
		send_imu(imu_of(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000));
		send_imu(imu_of(16'h00C8, 16'hFF38, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		wait_idle();
	endtask

	// Bias at both limits gives the widest rates; upper data bits are don't-care
	task automatic test_bias_limits();
		write_reg(REG_BIAS_X, 32'hABCD_8000);
		write_reg(REG_BIAS_Y, 32'h1234_7FFF);
		write_reg(REG_BIAS_Z, 32'hFFFF_FFFF);
		send_imu(imu_of(16'h0001, 16'h0002, 16'h0003, 16'h7FFF, 16'h8000, 16'h8000));
		send_imu(imu_of(16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h8000, 16'h7FFF, 16'h7FFF));
		send_imu(imu_of(16'h4000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		wait_idle();
		write_reg(REG_BIAS_EN, 32'hFFFF_FFFE);
		send_imu(imu_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
		send_imu(imu_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001));
		wait_idle();
		write_reg(REG_BIAS_EN, 32'h0000_0003);
		write_reg(REG_BIAS_X, 32'h0000_7FFF);
		write_reg(REG_BIAS_Y, 32'hFFFF_8000);
		write_reg(REG_BIAS_Z, 32'h5555_0001);
		send_imu(imu_of(16'h0101, 16'h0202, 16'h0303, 16'h8000, 16'h7FFF, 16'h8000));
		send_imu(imu_of(16'hFEFE, 16'hFDFD, 16'hFCFC, 16'h7FFF, 16'h8000, 16'h7FFF));
		wait_idle();
	endtask

	// Long runs fill the whole window; saturated ones push the averages to limits
	task automatic test_random_phases();
		fill_t       fill;
		int          count;
		logic [15:0] bias;
		for (int phase = 0; phase < 12; phase++) begin
			write_reg(REG_BIAS_EN, $urandom);
			for (int a = 0; a < 3; a++) begin
				bias = ($urandom_range(0, 2) == 0) ? pick_value(FILL_CORNER) : 16'($urandom);
				case (a)
					0: write_reg(REG_BIAS_X, {16'($urandom), bias});
					1: write_reg(REG_BIAS_Y, {16'($urandom), bias});
					default: write_reg(REG_BIAS_Z, {16'($urandom), bias});
				endcase
			end
			if (phase == 0)
				fill = FILL_HIGH;
			else if (phase == 1)
				fill = FILL_LOW;
			else
				fill = fill_t'($urandom_range(0, 3));
			count = $urandom_range(120, 170);
			for (int i = 0; i < count; i++)
				send_imu(make_imu(fill));
			wait_idle();
		end
	endtask

	initial begin : result_checker
		motion_t exp_r;
		int      gap;
		m_axis_tready = 1'b0;
		forever begin
			gap = draw_gap(recv_burst);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (pending_results.size() == 0) begin
				$error("result with no item pending: tdata %h", m_axis_tdata);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				for (int a = 0; a < 3; a++) begin
					if (m_axis_tdata[16*a +: 16] !== exp_r.avg[a]) begin
						$error("avg_%s mismatch: expected %0d, actual %0d", axis_tag[a],
						       $signed(exp_r.avg[a]), $signed(m_axis_tdata[16*a +: 16]));
						error_count++;
					end
					if (m_axis_tdata[48 + 17*a +: 17] !== exp_r.rate[a]) begin
						$error("rate_%s mismatch: expected %0d, actual %0d", axis_tag[a],
						       $signed(exp_r.rate[a]), $signed(m_axis_tdata[48 + 17*a +: 17]));
						error_count++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		error_count   = 0;
		send_burst    = 1'b0;
		recv_burst    = 1'b0;
		for (int s = 0; s < WIN; s++)
			for (int a = 0; a < 3; a++)
				ring_model[s][a] = '0;
		for (int a = 0; a < 3; a++) begin
			sum_model[a]  = 0;
			bias_model[a] = '0;
		end
		slot_model    = 0;
		bias_on_model = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_fill();
		test_bias_limits();
		test_random_phases();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("PASS three_axis_boxcar_average_unit");
		else
			$display("FAIL three_axis_boxcar_average_unit");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAIL three_axis_boxcar_average_unit");
		$finish;
	end

endmodule
